### sv/stepped_brightness_fade_ramp_macros.svh
// Assertion helpers for the fade ramp block.
// Every property is clocked on clk and disabled while rst_n is low.
`ifndef STEPPED_BRIGHTNESS_FADE_RAMP_MACROS_SVH
`define STEPPED_BRIGHTNESS_FADE_RAMP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SBFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbfr assertion failed");

// Next-cycle implication.
`define SBFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbfr assertion failed");

`else

`define SBFR_ASSERT_NOW(label, ante, cons)
`define SBFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/sbfr_pkg.sv
package sbfr_pkg;

    localparam int LevelW = 8;
    localparam int DurW   = 16;
    localparam int PcW    = 4;
    localparam int CntW   = 4;

    typedef logic [PcW-1:0]    pc_t;
    typedef logic [LevelW-1:0] level_t;

    // request commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_SET   = 2'd3;

    // microprogram addresses
    localparam pc_t PC_IDLE = pc_t'(0);
    localparam pc_t PC_TICK = pc_t'(1);
    localparam pc_t PC_STOP = pc_t'(2);
    localparam pc_t PC_SET  = pc_t'(3);
    localparam pc_t PC_PREP = pc_t'(4);
    localparam pc_t PC_DIVA = pc_t'(5);
    localparam pc_t PC_DIV2 = pc_t'(6);
    localparam pc_t PC_DIVB = pc_t'(7);
    localparam pc_t PC_FIN  = pc_t'(8);
    localparam pc_t PC_EMIT = pc_t'(9);

    // divider loop counts minus one: 9-bit numerator, then 16-bit numerator
    localparam logic [CntW-1:0] DIVA_LAST = CntW'(LevelW);
    localparam logic [CntW-1:0] DIVB_LAST = CntW'(DurW - 1);

    // config register byte address
    localparam logic [1:0] ADDR_STEP_SIZE = 2'd0;
    localparam level_t     STEP_SIZE_RST  = level_t'(4);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TICK,
        OP_STOP,
        OP_SET,
        OP_PREP,
        OP_DIV,
        OP_DIV2,
        OP_FIN,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DISPATCH,
        COND_CNT_NZ,
        COND_ZERO,
        COND_OUT_WAIT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // control store
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_JUMP, target: PC_IDLE};
        unique case (pc)
            PC_IDLE: w = '{op: OP_NOP,  cond: COND_DISPATCH, target: PC_IDLE};
            PC_TICK: w = '{op: OP_TICK, cond: COND_JUMP,     target: PC_EMIT};
            PC_STOP: w = '{op: OP_STOP, cond: COND_JUMP,     target: PC_EMIT};
            PC_SET:  w = '{op: OP_SET,  cond: COND_JUMP,     target: PC_EMIT};
            PC_PREP: w = '{op: OP_PREP, cond: COND_NEXT,     target: PC_IDLE};
            PC_DIVA: w = '{op: OP_DIV,  cond: COND_CNT_NZ,   target: PC_DIVA};
            PC_DIV2: w = '{op: OP_DIV2, cond: COND_ZERO,     target: PC_FIN};
            PC_DIVB: w = '{op: OP_DIV,  cond: COND_CNT_NZ,   target: PC_DIVB};
            PC_FIN:  w = '{op: OP_FIN,  cond: COND_NEXT,     target: PC_IDLE};
            PC_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_WAIT, target: PC_IDLE};
            default: w = '{op: OP_NOP,  cond: COND_JUMP,     target: PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic pc_t dispatch(input logic [1:0] cmd);
        pc_t p;
        p = PC_IDLE;
        unique case (cmd)
            CMD_TICK:  p = PC_TICK;
            CMD_START: p = PC_PREP;
            CMD_STOP:  p = PC_STOP;
            CMD_SET:   p = PC_SET;
            default:   p = PC_IDLE;
        endcase
        return p;
    endfunction

    // one step toward tgt, clamped at tgt
    function automatic level_t step_toward(input level_t cur, input level_t tgt,
                                           input logic up, input level_t st);
        logic [LevelW:0] sum;
        logic [LevelW:0] lim;
        level_t          res;
        sum = {1'b0, cur} + {1'b0, st};
        lim = {1'b0, tgt} + {1'b0, st};
        if (up) begin
            if (cur >= tgt || sum >= {1'b0, tgt}) res = tgt;
            else res = sum[LevelW-1:0];
        end
        else begin
            if (cur <= tgt || {1'b0, cur} < lim) res = tgt;
            else res = cur - st;
        end
        return res;
    endfunction

endpackage

### sv/stepped_brightness_fade_ramp.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------
// in       | in_valid / in_ready     | cmd, level, ramp_ms
// out      | out_valid / out_ready   | brightness, active, changed
// cfg      | APB psel/penable/pwrite | paddr, pwdata, prdata (step_size)
//
// One request at a time, run by a microprogram of ten control words.
// Tick, stop and set run one operation word and then the emit word, which
// loads the result register; the sequencer then returns to idle. A start runs
// the prepare word, then the shared shift-subtract divider (9 steps for the step
// count, 16 for the hold time), one quotient bit per cycle, then the finish and
// emit words; a start with zero steps skips the hold division.
// A new request is taken when the sequencer is back at its idle word; the
// result register lets that happen while the previous result still waits.
// A result that finds the result register still full holds the sequencer.
// rst_n clears all ramp state asynchronously; step_size resets to 4.
module stepped_brightness_fade_ramp
    import sbfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [LevelW-1:0]   level,
    input  logic [DurW-1:0]     ramp_ms,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LevelW-1:0]   brightness,
    output logic                active,
    output logic                changed,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    `include "stepped_brightness_fade_ramp_macros.svh"

    // sequencer
    pc_t              pc_reg, pc_next;
    uword_t           uw;
    logic [CntW-1:0]  cnt_reg;

    // ramp state
    level_t           step_size_reg;
    level_t           cur_reg;
    level_t           tgt_reg;
    logic             up_reg;
    logic [DurW-1:0]  hold_reg;
    logic [DurW-1:0]  tick_reg;
    logic             running_reg;
    logic             stop_reg;
    logic             changed_reg;
    logic             zero_reg;

    // request latch and divider
    level_t           lvl_reg;
    logic [DurW-1:0]  dur_reg;
    logic [DurW-1:0]  num_reg;
    level_t           rem_reg;
    level_t           den_reg;

    // result register
    logic             out_valid_reg;
    level_t           out_level_reg;
    logic             out_active_reg;
    logic             out_changed_reg;

    // datapath helpers
    level_t           eff_st;
    level_t           span;
    logic [LevelW:0]  n9;
    logic [LevelW:0]  trial;
    logic [LevelW:0]  diff;
    logic             ge;
    level_t           step_lvl;
    logic [DurW:0]    tick_inc;
    logic             out_busy;
    logic             accept;
    logic             cfg_wr;

    assign uw       = ucode(pc_reg);
    assign in_ready = (pc_reg == PC_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_busy = out_valid_reg && !out_ready;

    // step_size of zero acts as one
    assign eff_st = (step_size_reg == '0) ? level_t'(1) : step_size_reg;
    assign span   = (lvl_reg > cur_reg) ? (lvl_reg - cur_reg) : (cur_reg - lvl_reg);
    // ceil(span / st) numerator
    assign n9     = {1'b0, span} + {1'b0, eff_st} - (LevelW+1)'(1);

    // restoring divider step: remainder stays below the divisor
    assign trial  = {rem_reg, num_reg[DurW-1]};
    assign ge     = (trial >= {1'b0, den_reg});
    assign diff   = trial - {1'b0, den_reg};

    assign step_lvl = step_toward(cur_reg, tgt_reg, up_reg, eff_st);
    assign tick_inc = {1'b0, tick_reg} + (DurW+1)'(1);

    // next control word address
    always_comb
    begin
        pc_next = pc_reg + pc_t'(1);
        unique case (uw.cond)
            COND_NEXT:     pc_next = pc_reg + pc_t'(1);
            COND_JUMP:     pc_next = uw.target;
            COND_DISPATCH: pc_next = in_valid ? dispatch(cmd) : pc_reg;
            COND_CNT_NZ:   pc_next = (cnt_reg != '0) ? uw.target : pc_reg + pc_t'(1);
            COND_ZERO:     pc_next = (num_reg[LevelW-1:0] == '0) ? uw.target
                                                                 : pc_reg + pc_t'(1);
            COND_OUT_WAIT: pc_next = out_busy ? pc_reg : uw.target;
            default:       pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // config register: only the aligned word address holds step_size
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_STEP_SIZE);
    assign prdata = (paddr == ADDR_STEP_SIZE) ? {{(32-LevelW){1'b0}}, step_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            step_size_reg <= pwdata[LevelW-1:0];
        end
    end

    // ramp state, driven by the current control word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            tgt_reg     <= '0;
            up_reg      <= 1'b0;
            hold_reg    <= '0;
            tick_reg    <= '0;
            running_reg <= 1'b0;
            stop_reg    <= 1'b0;
            changed_reg <= 1'b0;
            zero_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (uw.op)
                OP_TICK:
                begin
                    changed_reg <= 1'b0;
                    if (running_reg)
                    begin
                        if (tick_inc >= {1'b0, hold_reg})
                        begin
                            tick_reg    <= '0;
                            changed_reg <= 1'b1;
                            if (stop_reg || cur_reg == tgt_reg)
                            begin
                                cur_reg     <= tgt_reg;
                                running_reg <= 1'b0;
                                stop_reg    <= 1'b0;
                            end
                            else
                            begin
                                cur_reg <= step_lvl;
                            end
                        end
                        else
                        begin
                            tick_reg <= tick_inc[DurW-1:0];
                        end
                    end
                end
                OP_STOP:
                begin
                    changed_reg <= 1'b0;
                    if (running_reg) stop_reg <= 1'b1;
                end
                OP_SET:
                begin
                    cur_reg     <= lvl_reg;
                    changed_reg <= 1'b1;
                end
                OP_PREP:
                begin
                    tgt_reg     <= lvl_reg;
                    up_reg      <= (lvl_reg > cur_reg);
                    stop_reg    <= 1'b0;
                    tick_reg    <= '0;
                    changed_reg <= 1'b1;
                    cnt_reg     <= DIVA_LAST;
                end
                OP_DIV:
                begin
                    if (cnt_reg != '0) cnt_reg <= cnt_reg - CntW'(1);
                end
                OP_DIV2:
                begin
                    zero_reg <= (num_reg[LevelW-1:0] == '0);
                    cnt_reg  <= DIVB_LAST;
                end
                OP_FIN:
                begin
                    if (zero_reg || num_reg == '0)
                    begin
                        hold_reg    <= zero_reg ? '0 : num_reg;
                        cur_reg     <= tgt_reg;
                        running_reg <= 1'b0;
                    end
                    else
                    begin
                        hold_reg    <= num_reg;
                        cur_reg     <= step_lvl;
                        running_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // request latch and divider registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lvl_reg <= level;
            dur_reg <= ramp_ms;
        end
        case (uw.op)
            OP_PREP:
            begin
                num_reg <= {n9, {(DurW-LevelW-1){1'b0}}};
                rem_reg <= '0;
                den_reg <= eff_st;
            end
            OP_DIV:
            begin
                num_reg <= {num_reg[DurW-2:0], ge};
                rem_reg <= ge ? diff[LevelW-1:0] : trial[LevelW-1:0];
            end
            OP_DIV2:
            begin
                num_reg <= dur_reg;
                rem_reg <= '0;
                den_reg <= num_reg[LevelW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uw.op == OP_EMIT && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.op == OP_EMIT && !out_busy)
        begin
            out_level_reg   <= cur_reg;
            out_active_reg  <= running_reg;
            out_changed_reg <= changed_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign brightness = out_level_reg;
    assign active     = out_active_reg;
    assign changed    = out_changed_reg;

    // a running ramp always has a nonzero hold and a tick count below it
    `SBFR_ASSERT_NOW(a_hold_nz, running_reg, hold_reg != '0)
    `SBFR_ASSERT_NOW(a_tick_lt_hold, running_reg, tick_reg < hold_reg)
    // a pending stop only exists during a ramp
    `SBFR_ASSERT_NOW(a_stop_running, stop_reg, running_reg)
    // the step-count division has fully drained before the hold division
    `SBFR_ASSERT_NOW(a_diva_done, pc_reg == PC_DIV2, cnt_reg == '0)
    // a result blocked by a full result register keeps the sequencer waiting
    `SBFR_ASSERT_NEXT(a_emit_hold, pc_reg == PC_EMIT && out_busy, pc_reg == PC_EMIT)

endmodule
